// ----- rtl/core/swpis_pkg.sv -----
// Shared types and constants for the sliding window pixel index scan.
package swpis_pkg;

  localparam int DIM_W = 11;
  localparam int CNT_W = 20;
  localparam int IDX_W = 3;

  typedef logic [DIM_W-1:0] dim_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [IDX_W-1:0] reg_idx_t;

  // Register indexes of the configuration port
  localparam reg_idx_t REG_IMAGE_WIDTH   = 3'd0;
  localparam reg_idx_t REG_IMAGE_HEIGHT  = 3'd1;
  localparam reg_idx_t REG_WINDOW_SIZE   = 3'd2;
  localparam reg_idx_t REG_WINDOW_STRIDE = 3'd3;

  localparam dim_t RESET_IMAGE_WIDTH   = 11'd64;
  localparam dim_t RESET_IMAGE_HEIGHT  = 11'd64;
  localparam dim_t RESET_WINDOW_SIZE   = 11'd8;
  localparam dim_t RESET_WINDOW_STRIDE = 11'd4;

  typedef struct packed {
    dim_t image_width;
    dim_t image_height;
    dim_t window_size;
    dim_t window_stride;
  } cfg_t;

  typedef struct packed {
    dim_t window_origin_x;
    dim_t window_origin_y;
    dim_t pixel_x;
    dim_t pixel_y;
    cnt_t window_counter;
    cnt_t position_counter;
    logic scan_finished;
  } scan_state_t;

  typedef struct packed {
    logic valid_res;
    cnt_t window_number;
    cnt_t position_in_window;
    cnt_t pixel_index;
    logic last_in_window;
    logic last_of_scan;
    logic done_res;
  } result_t;

endpackage

// ----- rtl/core/swpis_step.sv -----
// Next scan position and result word for one advance or restart.
module swpis_step
  import swpis_pkg::*;
(
  input  cfg_t        cfg,
  input  scan_state_t cur,
  input  logic        restart,
  output scan_state_t next,
  output result_t     res
);

  scan_state_t          s;
  dim_t                 stride;
  logic                 empty;
  logic [DIM_W:0]       w_ext;
  logic [DIM_W:0]       h_ext;
  logic [DIM_W:0]       ws_ext;
  logic [DIM_W:0]       xend;
  logic [DIM_W:0]       yend;
  logic [DIM_W:0]       ox_end;
  logic [DIM_W:0]       oy_end;
  logic [DIM_W:0]       px_inc;
  logic [DIM_W:0]       py_inc;
  logic [DIM_W+1:0]     col_reach;
  logic [DIM_W+1:0]     row_reach;
  logic [2*DIM_W-1:0]   row_base;
  logic [2*DIM_W-1:0]   index_full;
  logic                 liw;
  logic                 last_col;
  logic                 last_row;
  logic                 los;
  dim_t                 next_ox;

  // Restart clears the scan before this word is served
  assign s      = restart ? '0 : cur;
  assign stride = (cfg.window_stride == '0) ? dim_t'(1) : cfg.window_stride;

  assign w_ext  = {1'b0, cfg.image_width};
  assign h_ext  = {1'b0, cfg.image_height};
  assign ws_ext = {1'b0, cfg.window_size};

  // No window fits when the window exceeds the image by a full stride or more
  assign empty = (cfg.image_width == '0) || (cfg.image_height == '0) ||
                 (cfg.window_size == '0) ||
                 (ws_ext >= w_ext + {1'b0, stride}) ||
                 (ws_ext >= h_ext + {1'b0, stride});

  // Clip the window to the image
  assign ox_end = {1'b0, s.window_origin_x} + ws_ext;
  assign oy_end = {1'b0, s.window_origin_y} + ws_ext;
  assign xend   = (ox_end > w_ext) ? w_ext : ox_end;
  assign yend   = (oy_end > h_ext) ? h_ext : oy_end;

  assign px_inc = {1'b0, s.pixel_x} + 1'b1;
  assign py_inc = {1'b0, s.pixel_y} + 1'b1;
  assign liw    = (px_inc >= xend) && (py_inc >= yend);

  // Origins are stride multiples, so the last one is where a further step
  // would push the window past the image edge
  assign col_reach = {2'b0, s.window_origin_x} + {2'b0, stride} + {1'b0, ws_ext};
  assign row_reach = {2'b0, s.window_origin_y} + {2'b0, stride} + {1'b0, ws_ext};
  assign last_col  = col_reach > {1'b0, w_ext};
  assign last_row  = row_reach > {1'b0, h_ext};
  assign los       = liw && last_col && last_row;

  assign row_base   = s.pixel_y * cfg.image_width;
  assign index_full = row_base + {{DIM_W{1'b0}}, s.pixel_x};

  // Build the result word
  always_comb begin
    res = '0;
    if (s.scan_finished || empty) begin
      res.done_res = 1'b1;
    end else begin
      res.valid_res          = 1'b1;
      res.window_number      = s.window_counter;
      res.position_in_window = s.position_counter;
      res.pixel_index        = index_full[CNT_W-1:0];
      res.last_in_window     = liw;
      res.last_of_scan       = los;
    end
  end

  assign next_ox = last_col ? '0 : dim_t'(s.window_origin_x + stride);

  // Advance the scan position
  always_comb begin
    next = s;
    if (s.scan_finished || empty || los) begin
      next.scan_finished = 1'b1;
    end else if (!liw) begin
      next.position_counter = s.position_counter + 1'b1;
      if (px_inc >= xend) begin
        next.pixel_x = s.window_origin_x;
        next.pixel_y = py_inc[DIM_W-1:0];
      end else begin
        next.pixel_x = px_inc[DIM_W-1:0];
      end
    end else begin
      next.position_counter = '0;
      next.window_counter   = s.window_counter + 1'b1;
      next.window_origin_x  = next_ox;
      next.pixel_x          = next_ox;
      if (last_col) begin
        next.window_origin_y = dim_t'(s.window_origin_y + stride);
        next.pixel_y         = dim_t'(s.window_origin_y + stride);
      end else begin
        next.pixel_y = s.window_origin_y;
      end
    end
  end

endmodule

// ----- rtl/core/sliding_window_pixel_index_scan.sv -----
// A result word appears in the output register in the cycle after its input word is accepted.
// Throughput: one word per cycle while out_ready takes the output; one multiplier and the window compares sit between
// the scan state register and the output register.
// Reset: configuration returns to 64 x 64 image, window 8, stride 4; the scan restarts
// at window zero and the output register is empty. A write to a known register restarts the scan.
module sliding_window_pixel_index_scan
  import swpis_pkg::*;
#(
  parameter int MAX_DIM = 1024
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     cfg_write,
  input  reg_idx_t cfg_index,
  input  dim_t     cfg_data,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     restart,
  output logic     out_valid,
  input  logic     out_ready,
  output logic     valid_res,
  output cnt_t     window_number,
  output cnt_t     position_in_window,
  output cnt_t     pixel_index,
  output logic     last_in_window,
  output logic     last_of_scan,
  output logic     done_res
);

  cfg_t        cfg;
  scan_state_t scan;
  scan_state_t scan_next;
  result_t     res_next;
  result_t     res;
  dim_t        cfg_sat;
  logic        accept;

  // Saturate written values to the largest supported dimension
  assign cfg_sat = (32'(cfg_data) > MAX_DIM) ? dim_t'(MAX_DIM) : cfg_data;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  swpis_step u_step (
    .cfg     (cfg),
    .cur     (scan),
    .restart (restart),
    .next    (scan_next),
    .res     (res_next)
  );

  // Hold configuration; any known register write restarts the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width   <= RESET_IMAGE_WIDTH;
      cfg.image_height  <= RESET_IMAGE_HEIGHT;
      cfg.window_size   <= RESET_WINDOW_SIZE;
      cfg.window_stride <= RESET_WINDOW_STRIDE;
      scan              <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH: begin
          cfg.image_width <= cfg_sat;
          scan            <= '0;
        end
        REG_IMAGE_HEIGHT: begin
          cfg.image_height <= cfg_sat;
          scan             <= '0;
        end
        REG_WINDOW_SIZE: begin
          cfg.window_size <= cfg_sat;
          scan            <= '0;
        end
        REG_WINDOW_STRIDE: begin
          cfg.window_stride <= cfg_sat;
          scan              <= '0;
        end
        default: begin
        end
      endcase
    end else if (accept) begin
      scan <= scan_next;
    end
  end

  // Output register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

  assign valid_res          = res.valid_res;
  assign window_number      = res.window_number;
  assign position_in_window = res.position_in_window;
  assign pixel_index        = res.pixel_index;
  assign last_in_window     = res.last_in_window;
  assign last_of_scan       = res.last_of_scan;
  assign done_res           = res.done_res;

endmodule
